>>> hw/rtl/pcmup_pkg.sv
// Shared constants, configuration and control types of the PCM upsampler.
package pcmup_pkg;

	localparam int IDX_W   = 24;
	localparam int STEP_W  = 16;
	localparam int PROD_W  = IDX_W + STEP_W;
	localparam int SMP_W   = 16;
	localparam int RUN_MAX = 8;
	localparam int CNT_W   = $clog2(RUN_MAX + 1);
	localparam int ADDR_W  = 4;

	localparam logic [15:0] Q15_ONE = 16'h8000;

	localparam logic [1:0] REG_STEP_RATIO   = 2'd0;
	localparam logic [1:0] REG_ALPHA_COEFF  = 2'd1;
	localparam logic [1:0] REG_OUTPUT_TOTAL = 2'd2;

	typedef struct packed {
		logic [STEP_W-1:0] step_ratio;
		logic [15:0]       alpha_coeff;
		logic [IDX_W-1:0]  output_total;
	} cfg_t;

	typedef struct packed {
		logic load;     // take the accepted byte and apply restart
		logic mul;      // form output_index * step_ratio
		logic launch;   // start the filter multiplications
		logic finish;   // store the filtered sample as pending
		logic push;     // move the pending sample into the output register
		logic last;     // the pushed sample closes the run of this byte
		logic advance;  // step the source index
	} cmd_t;

	typedef struct packed {
		logic go;       // another output belongs to the current byte
		logic pend_v;   // a filtered sample waits to be pushed
		logic out_free; // the output register can take a beat this cycle
	} sts_t;

endpackage

>>> hw/rtl/pcmup_ctrl.sv
// Sequencer that walks each source byte through its output samples.
module pcmup_ctrl import pcmup_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_TEST,
		ST_FILT
	} state_t;

	state_t state_q;
	logic   can_push;

	assign can_push = !sts.pend_v || sts.out_free;
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
			end
			ST_TEST: begin
				if (can_push) begin
					cmd.push    = sts.pend_v;
					cmd.last    = !sts.go;
					cmd.launch  = sts.go;
					cmd.advance = !sts.go;
				end
			end
			ST_FILT: begin
				cmd.finish = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_TEST;
				end
				ST_TEST: begin
					if (can_push) state_q <= sts.go ? ST_FILT : ST_IDLE;
				end
				ST_FILT: begin
					state_q <= ST_MUL;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/pcmup_dp.sv
// Datapath: indices, phase multiplier, one-pole filter and output register.
module pcmup_dp import pcmup_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  cmd_t                    cmd,
	output sts_t                    sts,
	input  logic [7:0]              sample_byte,
	input  logic                    restart,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [SMP_W-1:0] out_sample,
	output logic                    last_of_run
);

	logic signed [SMP_W-1:0] x_q;
	logic signed [SMP_W-1:0] prev_q;
	logic signed [SMP_W-1:0] pend_y_q;
	logic                    pend_v_q;
	logic [IDX_W-1:0]        oi_q;
	logic [IDX_W-1:0]        si_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [PROD_W-1:0]       prod_s1;
	logic signed [32:0]      fa_s1;
	logic signed [32:0]      fb_s1;
	logic                    bypass_s1;
	logic                    out_valid_q;
	logic signed [SMP_W-1:0] out_sample_q;
	logic                    last_q;

	logic [15:0]             alpha_sat;
	logic [15:0]             alpha_inv;
	logic signed [33:0]      acc;
	logic signed [33:0]      acc_adj;
	logic signed [33:0]      acc_sh;
	logic signed [SMP_W-1:0] y;

	// Saturate the weight to one; its complement then also fits 16 bits.
	assign alpha_sat = (cfg.alpha_coeff > Q15_ONE) ? Q15_ONE : cfg.alpha_coeff;
	assign alpha_inv = Q15_ONE - alpha_sat;

	// Division by 32768 truncates toward zero, so negative sums are biased first.
	assign acc     = 34'(fa_s1) + 34'(fb_s1);
	assign acc_adj = acc[33] ? (acc + 34'sd32767) : acc;
	assign acc_sh  = acc_adj >>> 15;
	assign y       = bypass_s1 ? x_q : acc_sh[SMP_W-1:0];

	assign sts.go = (cnt_q < CNT_W'(RUN_MAX)) && (oi_q < cfg.output_total)
		&& (prod_s1[PROD_W-1:STEP_W] <= si_q);
	assign sts.pend_v   = pend_v_q;
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign out_sample  = out_sample_q;
	assign last_of_run = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oi_q        <= '0;
			si_q        <= '0;
			cnt_q       <= '0;
			prev_q      <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q <= '0;
				if (restart) begin
					oi_q <= '0;
					si_q <= '0;
				end
			end
			if (cmd.finish) begin
				prev_q   <= y;
				pend_v_q <= 1'b1;
				oi_q     <= oi_q + 1'b1;
				cnt_q    <= cnt_q + 1'b1;
			end
			if (cmd.advance) begin
				si_q <= si_q + 1'b1;
			end
			if (cmd.push) begin
				pend_v_q    <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= {~sample_byte[7], sample_byte[6:0], sample_byte};
		end
		if (cmd.mul) begin
			prod_s1 <= PROD_W'(oi_q) * PROD_W'(cfg.step_ratio);
		end
		if (cmd.launch) begin
			fa_s1     <= 33'($signed({1'b0, alpha_sat})) * 33'(x_q);
			fb_s1     <= 33'($signed({1'b0, alpha_inv})) * 33'(prev_q);
			bypass_s1 <= (oi_q == '0);
		end
		if (cmd.finish) begin
			pend_y_q <= y;
		end
		if (cmd.push) begin
			out_sample_q <= pend_y_q;
			last_q       <= cmd.last;
		end
	end

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!out_valid_q || !out_stall))
		else $error("sample pushed into an occupied output register");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(RUN_MAX))
		else $error("run count exceeds its limit");

	a_finish_pend: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> pend_v_q)
		else $error("filtered sample not held as pending");

	a_load_clean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !pend_v_q)
		else $error("pending sample left over from the previous byte");

endmodule

>>> hw/rtl/pcm8_upsampler_lowpass_unit.sv
// Top level of the 8-bit PCM upsampler with one-pole low-pass filter.
//
//  channel  direction  handshake            payload
//  input    in         in_valid/in_stall    sample_byte, restart
//  output   out        out_valid/out_stall  out_sample, last_of_run
//  config   in         APB write/read       step_ratio, alpha_coeff, output_total
//
// A byte yields 0 to 8 output samples; the shared sequencer takes each through its phase
// multiply, run test and filter stage, and takes a new byte only when back in idle.
// Reset clears indices, the previous output and the handshake state; registers
// return to step_ratio 65535, alpha_coeff 32768, output_total 0.
// Output stalls hold the sequencer in its run test until the output register frees.
module pcm8_upsampler_lowpass_unit import pcmup_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [ADDR_W-1:0]       paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [7:0]              sample_byte,
	input  logic                    restart,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [SMP_W-1:0] out_sample,
	output logic                    last_of_run
);

	cfg_t       cfg_q;
	cmd_t       cmd;
	sts_t       sts;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_ratio   <= 16'hFFFF;
			cfg_q.alpha_coeff  <= Q15_ONE;
			cfg_q.output_total <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_STEP_RATIO:   cfg_q.step_ratio   <= pwdata[STEP_W-1:0];
				REG_ALPHA_COEFF:  cfg_q.alpha_coeff  <= pwdata[15:0];
				REG_OUTPUT_TOTAL: cfg_q.output_total <= pwdata[IDX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_STEP_RATIO:   prdata = 32'(cfg_q.step_ratio);
			REG_ALPHA_COEFF:  prdata = 32'(cfg_q.alpha_coeff);
			REG_OUTPUT_TOTAL: prdata = 32'(cfg_q.output_total);
			default:          prdata = '0;
		endcase
	end

	pcmup_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	pcmup_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd         (cmd),
		.sts         (sts),
		.sample_byte (sample_byte),
		.restart     (restart),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_sample  (out_sample),
		.last_of_run (last_of_run)
	);

endmodule

>>> tb/pcm_upsample_checker.sv
// Checker for the PCM upsampler: predicts output samples from accepted bytes and compares them.
module pcm_upsample_checker import pcmup_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [ADDR_W-1:0]       paddr,
	input  logic [31:0]             pwdata,
	input  logic                    pready,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic [7:0]              sample_byte,
	input  logic                    restart,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic signed [SMP_W-1:0] out_sample,
	input  logic                    last_of_run,
	output int                      mismatches,
	output int                      pending,
	output int                      beats_checked
);

	typedef struct packed {
		logic signed [SMP_W-1:0] sample;
		logic                    closes_run;
	} sample_beat_t;

	sample_beat_t expected_samples[$];

	logic [STEP_W-1:0]       step_cfg;
	logic [15:0]             alpha_cfg;
	logic [IDX_W-1:0]        total_cfg;
	logic [IDX_W-1:0]        out_idx;
	logic [IDX_W-1:0]        src_idx;
	logic signed [SMP_W-1:0] prev_out;

	// Works out every output sample that one source byte releases.
	task automatic resample_byte(input logic [7:0] b, input logic rs);
		logic signed [SMP_W-1:0] wide;
		logic signed [SMP_W-1:0] y;
		logic [PROD_W-1:0]       phase;
		longint                  a;
		longint                  acc;
		int                      made;
		logic                    ahead;
		logic                    have_held;
		sample_beat_t            held;
		// byte*257 - 32768 is the byte repeated with its top bit inverted.
		wide = {b, b} ^ Q15_ONE;
		made = 0;
		ahead = 1'b0;
		have_held = 1'b0;
		held = '0;
		if (rs) begin
			out_idx = '0;
			src_idx = '0;
		end
		while (!ahead && made < RUN_MAX && out_idx < total_cfg) begin
			phase = PROD_W'(out_idx) * PROD_W'(step_cfg);
			if (phase[PROD_W-1:16] > src_idx) begin
				ahead = 1'b1;
			end else begin
				if (out_idx == '0) begin
					y = wide;
				end else begin
					a = (alpha_cfg > Q15_ONE) ? longint'(Q15_ONE) : longint'(alpha_cfg);
					acc = a * longint'(wide) + (longint'(Q15_ONE) - a) * longint'(prev_out);
					y = SMP_W'(acc / longint'(Q15_ONE));
				end
				prev_out = y;
				if (have_held)
					expected_samples.push_back(held);
				held.sample = y;
				held.closes_run = 1'b0;
				have_held = 1'b1;
				made++;
				out_idx = out_idx + 1'b1;
			end
		end
		if (have_held) begin
			held.closes_run = 1'b1;
			expected_samples.push_back(held);
		end
		src_idx = src_idx + 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		sample_beat_t want;
		if (!arst_n) begin
			step_cfg = 16'hFFFF;
			alpha_cfg = Q15_ONE;
			total_cfg = '0;
			out_idx = '0;
			src_idx = '0;
			prev_out = '0;
			expected_samples.delete();
			pending = 0;
			mismatches = 0;
			beats_checked = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_STEP_RATIO:   step_cfg = pwdata[STEP_W-1:0];
					REG_ALPHA_COEFF:  alpha_cfg = pwdata[15:0];
					REG_OUTPUT_TOTAL: total_cfg = pwdata[IDX_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_samples.size() == 0) begin
					if (mismatches < 10)
						$display("[%0t] unexpected output beat: out_sample %0d last_of_run %0b",
							$realtime, out_sample, last_of_run);
					mismatches++;
				end else begin
					want = expected_samples.pop_front();
					beats_checked++;
					if (want.sample !== out_sample || want.closes_run !== last_of_run) begin
						if (mismatches < 10)
							$display("[%0t] beat %0d: out_sample expected %0d got %0d, %s%0b got %0b",
								$realtime, beats_checked, want.sample, out_sample,
								"last_of_run expected ", want.closes_run, last_of_run);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall)
				resample_byte(sample_byte, restart);
			pending = expected_samples.size();
		end
	end

endmodule

>>> tb/testbench.sv
// Top of the PCM upsampler testbench: clock, reset, stimulus and verdict.
module testbench;
	import pcmup_pkg::*;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int SETTLE_CYCLES = 32;
	localparam int LONG_HOLD     = 300;
	localparam int PHASES        = 6;
	localparam int BYTES_PER_PHASE = 13;

	logic                    clk;
	logic                    arst_n;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [ADDR_W-1:0]       paddr;
	logic [31:0]             pwdata;
	logic [31:0]             prdata;
	logic                    pready;
	logic                    in_valid;
	logic                    in_stall;
	logic [7:0]              sample_byte;
	logic                    restart;
	logic                    out_valid;
	logic                    out_stall;
	logic signed [SMP_W-1:0] out_sample;
	logic                    last_of_run;

	int mismatches;
	int pending;
	int beats_checked;
	int cycle_count;
	int bytes_sent;
	int settings_used;

	logic calm;
	logic hold_request;
	logic [15:0] step_pick;
	logic [15:0] alpha_pick;
	logic [23:0] total_pick;

	pcm8_upsampler_lowpass_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .sample_byte(sample_byte), .restart(restart),
		.out_valid(out_valid), .out_stall(out_stall), .out_sample(out_sample),
		.last_of_run(last_of_run)
	);

	pcm_upsample_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .sample_byte(sample_byte), .restart(restart),
		.out_valid(out_valid), .out_stall(out_stall), .out_sample(out_sample),
		.last_of_run(last_of_run),
		.mismatches(mismatches), .pending(pending), .beats_checked(beats_checked)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("pcm8_upsampler_lowpass_unit test failed");
			$finish;
		end
	end

	// Offers one source byte after a random gap and returns at the falling edge after acceptance.
	task automatic feed(input logic [7:0] b, input logic rs);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample_byte <= b;
		restart <= rs;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Stops offering and waits until every predicted sample has come out.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		// A byte that yields no samples may still be in the sequencer.
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(input logic [15:0] step, input logic [15:0] alpha,
			input logic [23:0] total);
		drain();
		reg_write(REG_STEP_RATIO, 32'(step));
		reg_write(REG_ALPHA_COEFF, 32'(alpha));
		reg_write(REG_OUTPUT_TOTAL, 32'(total));
		settings_used++;
	endtask

	// Receiver: a random stall before each beat, and one long hold-off when asked.
	initial begin
		int gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = calm ? 0 : $urandom_range(0, 6);
			if (hold_request) begin
				gap = LONG_HOLD;
				hold_request = 1'b0;
			end
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!(out_valid && !out_stall)) @(posedge clk);
			@(negedge clk);
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		sample_byte = '0;
		restart = 1'b0;
		out_stall = 1'b0;
		cycle_count = 0;
		bytes_sent = 0;
		settings_used = 0;
		calm = 1'b0;
		hold_request = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings give a sound of length zero, so nothing comes out.
		feed(8'h00, 1'b1);
		feed(8'hFF, 1'b0);
		// Eight samples per byte, filter transparent, sound ends part way through a byte.
		configure(16'd8192, 16'd32768, 24'd20);
		feed(8'h00, 1'b1);
		feed(8'hFF, 1'b0);
		feed(8'h80, 1'b0);
		feed(8'h7F, 1'b0);
		// Filter frozen on the first sample, longest possible sound.
		configure(16'd65535, 16'd0, 24'hFFFFFF);
		feed(8'd200, 1'b1);
		feed(8'd17, 1'b0);
		feed(8'hFF, 1'b0);
		feed(8'h00, 1'b0);
		// Zero step keeps selecting old bytes; coefficient above one saturates.
		configure(16'd0, 16'hFFFF, 24'd100);
		feed(8'h01, 1'b1);
		feed(8'hFE, 1'b0);
		feed(8'h55, 1'b0);
		feed(8'hAA, 1'b1);
		// Tiny step wants far more than eight samples per byte.
		configure(16'd1000, 16'd12345, 24'd40);
		feed(8'd10, 1'b1);
		feed(8'd240, 1'b0);
		feed(8'd99, 1'b0);
		feed(8'd33, 1'b0);
		feed(8'd77, 1'b0);
		feed(8'd5, 1'b0);
		// A step change without restart leaves outputs behind the source.
		configure(16'd65535, 16'd20000, 24'd1000);
		feed(8'd50, 1'b1);
		feed(8'd60, 1'b0);
		feed(8'd70, 1'b0);
		configure(16'd8192, 16'd20000, 24'd1000);
		feed(8'd80, 1'b0);
		feed(8'd90, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			case ($urandom_range(0, 5))
				0: step_pick = 16'd8192;
				1: step_pick = 16'd65535;
				2: step_pick = 16'($urandom_range(0, 65535));
				default: step_pick = 16'($urandom_range(8192, 65535));
			endcase
			case ($urandom_range(0, 5))
				0: alpha_pick = 16'd0;
				1: alpha_pick = Q15_ONE;
				2: alpha_pick = 16'($urandom_range(32769, 65535));
				default: alpha_pick = 16'($urandom_range(0, 32768));
			endcase
			total_pick = ($urandom_range(0, 7) == 0) ? 24'hFFFFFF : 24'($urandom_range(0, 150));
			// One phase keeps the block busy on every byte while the receiver holds off.
			if (p == 1) begin
				step_pick = 16'd8192;
				total_pick = 24'hFFFFFF;
			end
			configure(step_pick, alpha_pick, total_pick);
			calm = (p == 3);
			if (p == 1)
				hold_request = 1'b1;
			for (int i = 0; i < BYTES_PER_PHASE; i++)
				feed(8'($urandom_range(0, 255)), (i == 0) || ($urandom_range(0, 19) == 0));
			calm = 1'b0;
		end
		drain();

		$display("Drove %0d source bytes under %0d register settings, with restarts, stalls",
			bytes_sent, settings_used);
		$display("and a long output hold-off; %0d filtered samples were compared.", beats_checked);
		if (mismatches == 0 && pending == 0) begin
			$display("pcm8_upsampler_lowpass_unit test passed");
		end else begin
			$display("pcm8_upsampler_lowpass_unit test failed");
		end
		$finish;
	end

endmodule

>>> pcm8_upsampler_lowpass_unit.f
hw/rtl/pcmup_pkg.sv
hw/rtl/pcmup_ctrl.sv
hw/rtl/pcmup_dp.sv
hw/rtl/pcm8_upsampler_lowpass_unit.sv
tb/pcm_upsample_checker.sv
tb/testbench.sv
